// ===== design/pcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle cell binning package
// Shared types, constants and opcodes of the cell binning unit.
// ----------------------------------------------------------------------------
package pcb_pkg;
	localparam int unsigned MAX_CELLS = 1024;
	localparam int unsigned MAX_SLOTS = 16;
	localparam int unsigned CELL_W = $clog2(MAX_CELLS);
	localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
	localparam int unsigned TAB_W = CELL_W + SLOT_W;

	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(MAX_CELLS - 1);
	localparam logic [CELL_W-1:0] CELL_STEP = CELL_W'(1);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] REG_CELL_WIDTH = 2'd0;
	localparam logic [1:0] REG_CELLS_X = 2'd1;
	localparam logic [1:0] REG_CELLS_Y = 2'd2;
	localparam logic [1:0] REG_SLOT_CAP = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [CELL_W-1:0] cell_idx;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_index;
		logic [15:0] slot_number;
		logic [15:0] cell_count;
		logic overflow;
		logic [15:0] particle_number;
		logic [15:0] required_capacity;
	} result_t;

	function automatic logic [5:0] sat_cells(input logic [5:0] n);
		if (n == 6'd0) return 6'd1;
		if (n > 6'd32) return 6'd32;
		return n;
	endfunction
endpackage

// ===== design/pcb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pcb_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/pcb_front.sv =====
// ----------------------------------------------------------------------------
// Cell binning front end
// Accepts words and, for inserts, divides positions by the cell width
// bit-serially and forms the clamped row-major cell index.
// ----------------------------------------------------------------------------
module pcb_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] opcode,
	input  logic [31:0] x_position,
	input  logic [31:0] y_position,
	input  logic [pcb_pkg::CELL_W-1:0] read_cell,
	input  logic [pcb_pkg::SLOT_W-1:0] read_slot,
	input  logic [31:0] cell_width,
	input  logic [5:0] cells_x,
	input  logic [5:0] cells_y,
	output logic cmd_valid,
	input  logic cmd_ready,
	output pcb_pkg::cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_IDX = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [4:0] bit_q;
	logic [31:0] qx_q, qy_q, rx_q, ry_q, nx_q, ny_q;
	logic [5:0] bx_q, by_q;
	pcb_pkg::cmd_t cmd_q;
	logic [32:0] rx_sh, ry_sh;
	logic [5:0] lx, ly;
	logic [11:0] idx;

	assign rx_sh = {rx_q, nx_q[31]};
	assign ry_sh = {ry_q, ny_q[31]};
	assign lx = pcb_pkg::sat_cells(cells_x) - 6'd1;
	assign ly = pcb_pkg::sat_cells(cells_y) - 6'd1;
	assign idx = 12'(by_q) * 12'(pcb_pkg::sat_cells(cells_x)) + 12'(bx_q);

	assign in_ready = (state_q == ST_IDLE);
	assign cmd_valid = (state_q == ST_OUT);
	assign cmd = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q.opcode <= opcode;
						cmd_q.cell_idx <= read_cell;
						cmd_q.slot <= read_slot;
						nx_q <= x_position;
						ny_q <= y_position;
						rx_q <= '0;
						ry_q <= '0;
						bit_q <= '0;
						state_q <= (opcode == pcb_pkg::OP_INSERT) ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					nx_q <= {nx_q[30:0], 1'b0};
					ny_q <= {ny_q[30:0], 1'b0};
					if (rx_sh >= {1'b0, cell_width}) begin
						rx_q <= 32'(rx_sh - {1'b0, cell_width});
						qx_q <= {qx_q[30:0], 1'b1};
					end else begin
						rx_q <= rx_sh[31:0];
						qx_q <= {qx_q[30:0], 1'b0};
					end
					if (ry_sh >= {1'b0, cell_width}) begin
						ry_q <= 32'(ry_sh - {1'b0, cell_width});
						qy_q <= {qy_q[30:0], 1'b1};
					end else begin
						ry_q <= ry_sh[31:0];
						qy_q <= {qy_q[30:0], 1'b0};
					end
					bit_q <= bit_q + 5'd1;
					if (bit_q == 5'd31) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					// A zero width gives all ones above, which clamps as required.
					bx_q <= (qx_q > 32'(lx)) ? lx : qx_q[5:0];
					by_q <= (qy_q > 32'(ly)) ? ly : qy_q[5:0];
					bit_q <= 5'd1;
					if (bit_q == 5'd1) begin
						cmd_q.cell_idx <= idx[pcb_pkg::CELL_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (cmd_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/pcb_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pcb_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  pcb_pkg::cmd_t wr_cmd,
	output logic rd_valid,
	input  logic rd_ready,
	output pcb_pkg::cmd_t rd_cmd
);
	pcb_pkg::cmd_t buf_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_cmd = buf_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== design/pcb_back.sv =====
// ----------------------------------------------------------------------------
// Cell binning back end
// Carries out clear, insert and read on the count and slot memories.
// ----------------------------------------------------------------------------
module pcb_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  pcb_pkg::cmd_t cmd,
	input  logic [4:0] slot_capacity,
	output logic res_valid,
	input  logic res_ready,
	output pcb_pkg::result_t res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_CLR = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	pcb_pkg::cmd_t cmd_q;
	logic [pcb_pkg::CELL_W-1:0] clr_q;
	logic clr_out_q;
	logic [15:0] next_q, max_q;
	pcb_pkg::result_t res_q, res_d;

	logic cnt_we, slot_we, ins_exec;
	logic [15:0] cnt_rdata, slot_rdata, cnt_now, cnt_new, cnt_wdata;
	logic [4:0] cap;
	logic [pcb_pkg::CELL_W-1:0] rcell, cnt_waddr;
	logic [pcb_pkg::SLOT_W-1:0] rslot;

	assign rcell = (state_q == ST_IDLE) ? cmd.cell_idx : cmd_q.cell_idx;
	assign rslot = (state_q == ST_IDLE) ? cmd.slot : cmd_q.slot;
	assign cnt_now = cnt_rdata;
	assign cnt_new = (cnt_now == 16'hFFFF) ? cnt_now : cnt_now + 16'd1;
	assign cap = (slot_capacity > 5'(pcb_pkg::MAX_SLOTS)) ?
		5'(pcb_pkg::MAX_SLOTS) : slot_capacity;
	assign ins_exec = (state_q == ST_EXEC) && (cmd_q.opcode == pcb_pkg::OP_INSERT);
	assign cnt_we = ins_exec || (state_q == ST_CLR);
	assign cnt_waddr = (state_q == ST_CLR) ? clr_q : cmd_q.cell_idx;
	assign cnt_wdata = (state_q == ST_CLR) ? 16'd0 : cnt_new;
	assign slot_we = ins_exec && (cnt_now < 16'(cap));

	pcb_ram #(.WIDTH(16), .DEPTH(pcb_pkg::MAX_CELLS)) u_counts (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(rcell), .rdata(cnt_rdata)
	);
	pcb_ram #(.WIDTH(16), .DEPTH(pcb_pkg::MAX_CELLS * pcb_pkg::MAX_SLOTS)) u_slots (
		.clk(clk), .we(slot_we),
		.waddr({cmd_q.cell_idx, cnt_now[pcb_pkg::SLOT_W-1:0]}), .wdata(next_q),
		.raddr({rcell, rslot}), .rdata(slot_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res = res_q;

	always_comb begin
		res_d = '0;
		res_d.required_capacity = max_q;
		unique case (cmd_q.opcode)
			pcb_pkg::OP_CLEAR: res_d.required_capacity = '0;
			pcb_pkg::OP_INSERT: begin
				res_d.cell_index = cmd_q.cell_idx;
				res_d.slot_number = cnt_now;
				res_d.cell_count = cnt_new;
				res_d.overflow = (cnt_now >= 16'(cap));
				res_d.particle_number = next_q;
				if (cnt_new > max_q) begin
					res_d.required_capacity = cnt_new;
				end
			end
			pcb_pkg::OP_READ: begin
				res_d.cell_index = cmd_q.cell_idx;
				res_d.slot_number = 16'(cmd_q.slot);
				res_d.cell_count = cnt_now;
				res_d.particle_number = slot_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			next_q <= '0;
			max_q <= '0;
			clr_q <= '0;
			clr_out_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EXEC;
				ST_EXEC: begin
					res_q <= res_d;
					unique case (cmd_q.opcode)
						pcb_pkg::OP_CLEAR: begin
							next_q <= '0;
							max_q <= '0;
							clr_q <= '0;
							clr_out_q <= 1'b1;
							state_q <= ST_CLR;
						end
						pcb_pkg::OP_INSERT: begin
							next_q <= next_q + 16'd1;
							if (cnt_new > max_q) begin
								max_q <= cnt_new;
							end
							state_q <= ST_OUT;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_CLR: begin
					clr_q <= clr_q + pcb_pkg::CELL_STEP;
					if (clr_q == pcb_pkg::CELL_LAST) begin
						state_q <= clr_out_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/particle_cell_binning_unit.sv =====
// ----------------------------------------------------------------------------
// Particle cell binning unit
// Bins 2D Q16.16 particle positions into a uniform grid of cells.
// ----------------------------------------------------------------------------
// Words enter on the s_axis channel: opcode clear, insert or read. Each word
// gives exactly one result word on the m_axis channel. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it
// only while the unit is idle, as the block itself does not enforce this.
// For an insert the front end divides x and y bit-serially by the cell width
// (32 quotient bits, both axes in parallel), then clamps and forms the index.
// It takes a new word only once it has handed the last one on. Other words
// pass the front end without division. The back end does a read-modify-write
// of the cell count: it reads the count, then writes the updated count in its
// execute state. A clear adds a pass that zeroes every cell count before its
// result is given.
// A two-word queue parts the front end from the back end, and the result
// register parts the back end from the receiver, so the front end keeps
// dividing while a result waits. When the receiver stalls, results hold
// and the input side stops once the queue is full.
// Reset zeroes the particle counter and the required capacity, loads the
// register defaults (width 1.0, 32 by 32 cells, capacity 16) and starts the
// same clearing pass; words accepted meanwhile wait in the queue.
// ----------------------------------------------------------------------------
module particle_cell_binning_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[1:0], x_position[33:2], y_position[65:34], read_cell[75:66],
	// read_slot[79:76]
	input  logic [79:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// cell_index[9:0], slot_number[25:10], cell_count[41:26], overflow[42],
	// particle_number[58:43], required_capacity[74:59]
	output logic [79:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] cell_width_q;
	logic [5:0] cells_x_q, cells_y_q;
	logic [4:0] slot_cap_q;
	logic f_valid, f_ready, b_valid, b_ready;
	pcb_pkg::cmd_t f_cmd, b_cmd;
	pcb_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q <= 32'd65536;
			cells_x_q <= 6'd32;
			cells_y_q <= 6'd32;
			slot_cap_q <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcb_pkg::REG_CELL_WIDTH: cell_width_q <= cfg_data;
				pcb_pkg::REG_CELLS_X: cells_x_q <= cfg_data[5:0];
				pcb_pkg::REG_CELLS_Y: cells_y_q <= cfg_data[5:0];
				pcb_pkg::REG_SLOT_CAP: slot_cap_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	pcb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.opcode(s_axis_tdata[1:0]), .x_position(s_axis_tdata[33:2]),
		.y_position(s_axis_tdata[65:34]), .read_cell(s_axis_tdata[75:66]),
		.read_slot(s_axis_tdata[79:76]),
		.cell_width(cell_width_q), .cells_x(cells_x_q), .cells_y(cells_y_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pcb_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd)
	);

	pcb_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.slot_capacity(slot_cap_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'd0, res.required_capacity, res.particle_number,
		res.overflow, res.cell_count, res.slot_number, res.cell_index};
endmodule
